// File: rtl/assert_macros.svh
// assertion macros used by the level meter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked property, disabled while reset is low
`define MLM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked property, also active during reset
`define MLM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MLM_ASSERT(lbl, clk, rstn, prop, msg)
`define MLM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/mlm_pkg.sv
// types and constants of the microphone level meter
`default_nettype none

package mlm_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int LEVEL_W   = 12;
    localparam int PCT_W     = 7;
    localparam int SUM_W     = 28;
    localparam int COUNT_W   = 16;
    localparam int DC_W      = 28;
    localparam int PROD_W    = 28;
    localparam int REM_W     = 16;
    localparam int STEP_W    = 4;

    // register indexes
    localparam logic [1:0] REG_DC_START = 2'd0;
    localparam logic [1:0] REG_DC_SHIFT = 2'd1;
    localparam logic [1:0] REG_WEIGHT   = 2'd2;
    localparam logic [1:0] REG_FULL     = 2'd3;

    // register reset values
    localparam logic [11:0] RST_DC_START = 12'd2048;
    localparam logic [3:0]  RST_DC_SHIFT = 4'd8;
    localparam logic [15:0] RST_WEIGHT   = 16'd4096;
    localparam logic [15:0] RST_FULL     = 16'd4095;

    localparam logic [15:0]      Q15_ONE   = 16'd32768;
    localparam logic [11:0]      LEVEL_MAX = 12'd4095;
    localparam logic [6:0]       PCT_MAX   = 7'd100;
    localparam logic [15:0]      PCT_MUL   = 16'd100;
    localparam logic [SUM_W-1:0] SUM_MAX   = 28'hFFFFFFF;

    // divider passes: block mean and percentage
    localparam logic [STEP_W-1:0] DIV_MEAN_STEPS = 4'd12;
    localparam logic [STEP_W-1:0] DIV_PCT_STEPS  = 4'd7;

    typedef struct packed {
        logic              start;
        logic [REM_W-1:0]  rem;
        logic [11:0]       bits;
        logic [STEP_W-1:0] steps;
        logic [REM_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [11:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

// File: rtl/microphone_level_meter.sv
// microphone level meter: dc removal, block mean magnitude, smoothed level
//
//  channel   direction  handshake               payload
//  s_axis    in         tvalid/tready           tdata sample, tlast last_in_block
//  m_axis    out        tvalid/tready           tdata level, level_percent
//  apb       in         psel/penable/pready     4 registers at 0x0..0xc
//
// a sample that does not end a block passes through accept, dc update and sum
// a block end adds the mean division (12 steps and done), the blend, the percent product,
// the start and run of the percent division and the output register; the percent division
// is skipped when the percent caps at 100
// reset is synchronous; a result waiting in the output register stalls the next block end
// in the output state, and no new samples are taken meanwhile
`default_nettype none
`include "assert_macros.svh"

module microphone_level_meter #(
    parameter int SAMPLE_BITS = 12,
    parameter int MAX_BLOCK   = 65535
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input samples
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [11:0] sample
    input  wire logic        s_axis_tlast,   // last_in_block
    // results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [11:0] level, [18:12] level_percent
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [mlm_pkg::COUNT_W-1:0] MAX_BLK = mlm_pkg::COUNT_W'(MAX_BLOCK);
    localparam logic [mlm_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
        mlm_pkg::SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DC    = 4'd1;
    localparam logic [3:0] ST_MAG   = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_MULA  = 4'd4;
    localparam logic [3:0] ST_MULB  = 4'd5;
    localparam logic [3:0] ST_BLEND = 4'd6;
    localparam logic [3:0] ST_PMUL  = 4'd7;
    localparam logic [3:0] ST_PDIV0 = 4'd8;
    localparam logic [3:0] ST_PDIV  = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // configuration registers
    logic [11:0] r_cfg_start;
    logic [3:0]  r_cfg_shift;
    logic [15:0] r_cfg_weight;
    logic [15:0] r_cfg_fs;

    // running state
    logic [mlm_pkg::DC_W-1:0]     r_dc;
    logic [mlm_pkg::LEVEL_W-1:0]  r_smoothed;
    logic [mlm_pkg::SUM_W-1:0]    r_sum;
    logic [mlm_pkg::COUNT_W-1:0]  r_count;

    // working registers
    logic [mlm_pkg::SAMPLE_W-1:0] r_x;
    logic                         r_last;
    logic [mlm_pkg::PROD_W-1:0]   r_prod;
    logic [mlm_pkg::PROD_W-1:0]   r_acc;
    logic [mlm_pkg::PCT_W-1:0]    r_pct;

    // output register
    logic                         r_out_valid;
    logic [mlm_pkg::LEVEL_W-1:0]  r_out_level;
    logic [mlm_pkg::PCT_W-1:0]    r_out_pct;

    mlm_pkg::t_div_req div_req;
    mlm_pkg::t_div_rsp div_rsp;

    logic                           cfg_wr;
    logic                           in_acc;
    logic [mlm_pkg::DC_W-1:0]       xq;
    logic signed [mlm_pkg::DC_W:0]  err;
    logic signed [mlm_pkg::DC_W:0]  err_sh;
    logic signed [mlm_pkg::DC_W:0]  dc_sum;
    logic signed [mlm_pkg::DC_W:0]  ac;
    logic [mlm_pkg::DC_W:0]         ac_abs;
    logic [mlm_pkg::LEVEL_W-1:0]    mag;
    logic [mlm_pkg::SUM_W:0]        sum_add;
    logic [mlm_pkg::SUM_W-1:0]      sum_sat;
    logic [mlm_pkg::COUNT_W-1:0]    count_inc;
    logic                           blk_end;
    logic [15:0]                    w_clip;
    logic [mlm_pkg::LEVEL_W-1:0]    mul_a;
    logic [15:0]                    mul_b;
    logic [mlm_pkg::PROD_W:0]       blend_sum;
    logic [13:0]                    blend;
    logic [mlm_pkg::LEVEL_W-1:0]    blend_sat;
    logic                           pct_ovf;
    logic [mlm_pkg::PCT_W-1:0]      pct_q;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // dc tracker: estimate moves by the error shifted right arithmetically
    assign xq     = {r_x, 16'b0};
    assign err    = $signed({1'b0, xq}) - $signed({1'b0, r_dc});
    assign err_sh = err >>> r_cfg_shift;
    assign dc_sum = $signed({1'b0, r_dc}) + err_sh;

    // magnitude of the dc-removed sample, integer part only
    assign ac        = $signed({1'b0, xq}) - $signed({1'b0, r_dc});
    assign ac_abs    = ac[mlm_pkg::DC_W] ? (-ac) : ac;
    assign mag       = ac_abs[27:16];
    assign sum_add   = {1'b0, r_sum} + {17'b0, mag};
    assign sum_sat   = sum_add[mlm_pkg::SUM_W] ? mlm_pkg::SUM_MAX
                                               : sum_add[mlm_pkg::SUM_W-1:0];
    assign count_inc = r_count + 1'b1;
    assign blk_end   = r_last || (count_inc >= MAX_BLK);

    // shared multiplier operands
    assign w_clip = (r_cfg_weight > mlm_pkg::Q15_ONE) ? mlm_pkg::Q15_ONE : r_cfg_weight;

    always_comb begin
        mul_a = r_smoothed;
        mul_b = mlm_pkg::PCT_MUL;
        case (r_state)
            ST_MULA: begin
                mul_a = r_smoothed;
                mul_b = mlm_pkg::Q15_ONE - w_clip;
            end
            ST_MULB: begin
                mul_a = div_rsp.quot;
                mul_b = w_clip;
            end
            default: begin
                mul_a = r_smoothed;
                mul_b = mlm_pkg::PCT_MUL;
            end
        endcase
    end

    assign blend_sum = {1'b0, r_acc} + {1'b0, r_prod};
    assign blend     = blend_sum[28:15];
    assign blend_sat = (blend > {2'b0, mlm_pkg::LEVEL_MAX}) ? mlm_pkg::LEVEL_MAX
                                                            : blend[11:0];

    // a percent quotient of 128 or more cannot come from the 7-step pass
    assign pct_ovf = {4'b0, r_prod[18:7]} >= r_cfg_fs;
    assign pct_q   = (div_rsp.quot[6:0] > mlm_pkg::PCT_MAX) ? mlm_pkg::PCT_MAX
                                                            : div_rsp.quot[6:0];

    always_comb begin
        div_req = '0;
        case (r_state)
            ST_MAG: begin
                div_req.start   = blk_end;
                div_req.rem     = sum_sat[27:12];
                div_req.bits    = sum_sat[11:0];
                div_req.steps   = mlm_pkg::DIV_MEAN_STEPS;
                div_req.divisor = count_inc;
            end
            ST_PDIV0: begin
                div_req.start   = !pct_ovf;
                div_req.rem     = {4'b0, r_prod[18:7]};
                div_req.bits    = {r_prod[6:0], 5'b0};
                div_req.steps   = mlm_pkg::DIV_PCT_STEPS;
                div_req.divisor = r_cfg_fs;
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    mlm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_acc) n_state = ST_DC;
            ST_DC:    n_state = ST_MAG;
            ST_MAG:   n_state = blk_end ? ST_DIV : ST_IDLE;
            ST_DIV:   if (div_rsp.done) n_state = ST_MULA;
            ST_MULA:  n_state = ST_MULB;
            ST_MULB:  n_state = ST_BLEND;
            ST_BLEND: n_state = ST_PMUL;
            ST_PMUL:  n_state = ST_PDIV0;
            ST_PDIV0: n_state = pct_ovf ? ST_OUT : ST_PDIV;
            ST_PDIV:  if (div_rsp.done) n_state = ST_OUT;
            ST_OUT:   if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cfg_start  <= mlm_pkg::RST_DC_START;
            r_cfg_shift  <= mlm_pkg::RST_DC_SHIFT;
            r_cfg_weight <= mlm_pkg::RST_WEIGHT;
            r_cfg_fs     <= mlm_pkg::RST_FULL;
            r_dc         <= {mlm_pkg::RST_DC_START, 16'b0};
            r_smoothed   <= '0;
            r_sum        <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_DC: begin
                    r_dc <= dc_sum[mlm_pkg::DC_W-1:0];
                end
                ST_MAG: begin
                    if (blk_end) begin
                        r_sum   <= '0;
                        r_count <= '0;
                    end else begin
                        r_sum   <= sum_sat;
                        r_count <= count_inc;
                    end
                end
                ST_BLEND: begin
                    r_smoothed <= blend_sat;
                end
                default: begin
                end
            endcase
            if (cfg_wr) begin
                case (paddr[3:2])
                    mlm_pkg::REG_DC_START: begin
                        r_cfg_start <= pwdata[11:0];
                        r_dc        <= {pwdata[11:0], 16'b0};
                        r_smoothed  <= '0;
                    end
                    mlm_pkg::REG_DC_SHIFT: r_cfg_shift  <= pwdata[3:0];
                    mlm_pkg::REG_WEIGHT:   r_cfg_weight <= pwdata[15:0];
                    mlm_pkg::REG_FULL: begin
                        r_cfg_fs <= (pwdata[15:0] == 16'd0) ? mlm_pkg::RST_FULL
                                                            : pwdata[15:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x    <= s_axis_tdata[11:0] & SAMPLE_MASK;
            r_last <= s_axis_tlast;
        end
        case (r_state)
            ST_MULA:  r_prod <= {16'b0, mul_a} * {12'b0, mul_b};
            ST_MULB: begin
                r_acc  <= r_prod;
                r_prod <= {16'b0, mul_a} * {12'b0, mul_b};
            end
            ST_PMUL:  r_prod <= {16'b0, mul_a} * {12'b0, mul_b};
            ST_PDIV0: r_pct  <= mlm_pkg::PCT_MAX;
            ST_PDIV:  if (div_rsp.done) r_pct <= pct_q;
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    r_out_level <= r_smoothed;
                    r_out_pct   <= r_pct;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (paddr[3:2])
            mlm_pkg::REG_DC_START: prdata = {20'b0, r_cfg_start};
            mlm_pkg::REG_DC_SHIFT: prdata = {28'b0, r_cfg_shift};
            mlm_pkg::REG_WEIGHT:   prdata = {16'b0, r_cfg_weight};
            mlm_pkg::REG_FULL:     prdata = {16'b0, r_cfg_fs};
            default:               prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_pct, r_out_level};

    `MLM_ASSERT(a_pct_cap, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tdata[18:12] <= 7'd100), "percent above cap")
    `MLM_ASSERT(a_count_bound, i_clk, i_rst_n, r_count < MAX_BLK, "block count reached its limit")
    `MLM_ASSERT(a_div_done, i_clk, i_rst_n, div_rsp.done |-> (r_state == ST_DIV || r_state == ST_PDIV), "divider finished outside a wait state")
    `MLM_ASSERT(a_accept_dc, i_clk, i_rst_n, in_acc |=> (r_state == ST_DC), "accepted sample skipped the dc update")

endmodule

`default_nettype wire

// File: rtl/mlm_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module mlm_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mlm_pkg::t_div_req i_req,
    output mlm_pkg::t_div_rsp      o_rsp
);

    logic                               r_busy;
    logic                               r_done;
    logic [mlm_pkg::STEP_W-1:0]         r_cnt;
    logic [mlm_pkg::REM_W-1:0]          r_rem;
    logic [mlm_pkg::REM_W-1:0]          r_div;
    logic [11:0]                        r_bits;
    logic [11:0]                        r_quot;

    logic [mlm_pkg::REM_W:0] trial;
    logic [mlm_pkg::REM_W:0] diff;
    logic                    ge;

    // remainder always stays below the divisor
    assign trial = {r_rem, r_bits[11]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.rem;
            r_div  <= i_req.divisor;
            r_bits <= i_req.bits;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[mlm_pkg::REM_W-1:0] : trial[mlm_pkg::REM_W-1:0];
            r_bits <= {r_bits[10:0], 1'b0};
            r_quot <= {r_quot[10:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

`default_nettype wire

// File: tb/tb.sv
// testbench of the microphone level meter: table and random stimulus against a predictor
`timescale 1ns / 100ps

module tb;

    localparam int SETTLE_CYCLES = 40;
    localparam int BLOCK_LIMIT   = 65535;
    localparam int WEIGHT_ONE    = 32768;
    localparam int LEVEL_TOP     = 4095;
    localparam int PCT_TOP       = 100;
    localparam longint MAG_SUM_SAT = 64'h0FFF_FFFF;

    typedef struct packed {
        logic [11:0] level;
        logic [6:0]  pct;
    } t_level_result;

    typedef struct packed {
        logic        is_write;
        logic [1:0]  reg_idx;
        logic [31:0] wdata;
        logic [11:0] sample;
        logic        last;
        logic        known;
        logic [11:0] level;
        logic [6:0]  pct;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire logic   s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    wire logic   m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire logic [23:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire logic [31:0] prdata;
    wire logic   pready;

    microphone_level_meter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    // predictor copy of settings and state
    int     cfg_start  = 2048;
    int     cfg_shift  = 8;
    int     cfg_weight = 4096;
    int     cfg_full   = 4095;
    int     dc_est     = 2048 << 16;
    int     cur_level  = 0;
    longint mag_sum    = 0;
    int     blk_count  = 0;

    t_level_result expected_levels[$];
    t_level_result mon_want;
    t_dir_row      directed_rows[$];
    int            fails = 0;
    int            burst_left = 0;

    // one sample into the predictor, returns 1 when a block ends
    function automatic bit level_step(input logic [11:0] x, input logic last,
                                      output t_level_result res);
        int     x_q16;
        int     err;
        int     ac;
        int     mag;
        int     wt;
        longint blk_lvl;
        longint blend;
        longint pc;
        x_q16 = {4'd0, x, 16'h0000};
        err = x_q16 - dc_est;
        dc_est = dc_est + (err >>> cfg_shift);
        ac = x_q16 - dc_est;
        mag = (ac < 0) ? -ac : ac;
        mag = mag >>> 16;
        mag_sum = mag_sum + mag;
        if (mag_sum > MAG_SUM_SAT) mag_sum = MAG_SUM_SAT;
        blk_count = blk_count + 1;
        res = '0;
        if (!last && blk_count < BLOCK_LIMIT) return 1'b0;
        blk_lvl = mag_sum / blk_count;
        mag_sum = 0;
        blk_count = 0;
        wt = (cfg_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg_weight;
        blend = (longint'(cur_level) * (WEIGHT_ONE - wt) + blk_lvl * wt) >>> 15;
        cur_level = (blend > LEVEL_TOP) ? LEVEL_TOP : int'(blend);
        pc = (longint'(cur_level) * PCT_TOP) / cfg_full;
        if (pc > PCT_TOP) pc = PCT_TOP;
        res.level = 12'(cur_level);
        res.pct = 7'(pc);
        return 1'b1;
    endfunction

    function automatic t_dir_row row_item(input logic [11:0] s, input logic l);
        t_dir_row r;
        r = '0;
        r.sample = s;
        r.last = l;
        return r;
    endfunction

    function automatic t_dir_row row_known(input logic [11:0] s, input logic l,
                                           input logic [11:0] lv, input logic [6:0] pc);
        t_dir_row r;
        r = row_item(s, l);
        r.known = 1'b1;
        r.level = lv;
        r.pct = pc;
        return r;
    endfunction

    function automatic t_dir_row row_write(input logic [1:0] idx, input logic [31:0] val);
        t_dir_row r;
        r = '0;
        r.is_write = 1'b1;
        r.reg_idx = idx;
        r.wdata = val;
        return r;
    endfunction

    // setup and access phase, then the bus returns to idle
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            mlm_pkg::REG_DC_START: begin
                cfg_start = val[11:0];
                dc_est = {4'd0, val[11:0], 16'h0000};
                cur_level = 0;
            end
            mlm_pkg::REG_DC_SHIFT: cfg_shift = val[3:0];
            mlm_pkg::REG_WEIGHT:   cfg_weight = val[15:0];
            mlm_pkg::REG_FULL:     cfg_full = (val[15:0] == 16'd0) ? 4095 : val[15:0];
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    // hold the sample until the transaction completes, then pace the bursts
    task automatic send_sample(input logic [11:0] smp, input logic last,
                               input logic known, input t_level_result known_res);
        t_level_result got;
        int            gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, smp};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (level_step(smp, last, got)) expected_levels.push_back(known ? known_res : got);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 31);
        end
    endtask

    // sender pauses until every pending level has come out and the block is idle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_settings();
        int r;
        drain_results();
        if ($urandom_range(0, 1)) begin
            r = $urandom_range(0, 5);
            reg_write(mlm_pkg::REG_DC_START,
                      (r == 0) ? 0 : (r == 1) ? 4095 : $urandom_range(0, 4095));
        end
        r = $urandom_range(0, 5);
        reg_write(mlm_pkg::REG_DC_SHIFT,
                  (r == 0) ? 0 : (r == 1) ? 15 : $urandom_range(0, 15));
        r = $urandom_range(0, 9);
        case (r)
            0:       reg_write(mlm_pkg::REG_WEIGHT, 0);
            1:       reg_write(mlm_pkg::REG_WEIGHT, 32768);
            2:       reg_write(mlm_pkg::REG_WEIGHT, 65535);
            3:       reg_write(mlm_pkg::REG_WEIGHT, $urandom_range(32769, 65535));
            default: reg_write(mlm_pkg::REG_WEIGHT, $urandom_range(0, 32768));
        endcase
        r = $urandom_range(0, 11);
        case (r)
            0:       reg_write(mlm_pkg::REG_FULL, 0);
            1:       reg_write(mlm_pkg::REG_FULL, 1);
            2:       reg_write(mlm_pkg::REG_FULL, 65535);
            3:       reg_write(mlm_pkg::REG_FULL, $urandom_range(1, 65535));
            default: reg_write(mlm_pkg::REG_FULL, $urandom_range(500, 4095));
        endcase
    endtask

    // blocks of random length; a phase may end inside a block
    task automatic random_phase(input int budget);
        int          blk_len;
        int          mode;
        int          centre;
        int          amp;
        int          v;
        int          r;
        int          i;
        bit          noisy;
        logic [11:0] smp;
        logic        last;
        while (budget > 0) begin
            r = $urandom_range(0, 99);
            if (r < 75) blk_len = $urandom_range(1, 8);
            else if (r < 98) blk_len = $urandom_range(9, 40);
            else blk_len = $urandom_range(41, 200);
            mode = $urandom_range(0, 3);
            centre = $urandom_range(0, 1) ? cfg_start : $urandom_range(0, 4095);
            amp = (mode == 2) ? $urandom_range(0, 2047) : $urandom_range(0, 15);
            noisy = ($urandom_range(0, 15) == 0);
            for (i = 0; i < blk_len && budget > 0; i++) begin
                case (mode)
                    0: smp = 12'($urandom_range(0, 4095));
                    1: smp = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
                    default: begin
                        v = centre + int'($urandom_range(0, 2 * amp)) - amp;
                        if (v < 0) v = 0;
                        if (v > 4095) v = 4095;
                        smp = 12'(v);
                    end
                endcase
                last = (i == blk_len - 1) || (noisy && $urandom_range(0, 3) == 0);
                send_sample(smp, last, 1'b0, '0);
                budget--;
            end
            if ($urandom_range(0, 19) == 0) drain_results();
        end
    endtask

    // receiver stall pattern: modes held for random stretches
    int rx_left = 0;
    int rx_mode = 0;
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left = rx_left - 1;
        end
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_levels.size() == 0) begin
                $display("%0t: unexpected result level %0d percent %0d", $time,
                         m_axis_tdata[11:0], m_axis_tdata[18:12]);
                fails++;
            end else begin
                mon_want = expected_levels.pop_front();
                if (m_axis_tdata[11:0] !== mon_want.level) begin
                    $display("%0t: level expected %0d got %0d", $time,
                             mon_want.level, m_axis_tdata[11:0]);
                    fails++;
                end
                if (m_axis_tdata[18:12] !== mon_want.pct) begin
                    $display("%0t: level_percent expected %0d got %0d", $time,
                             mon_want.pct, m_axis_tdata[18:12]);
                    fails++;
                end
            end
        end
    end

    initial begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int            p;
        t_dir_row      row;
        t_level_result kres;

        // reset settings, a sample at the midpoint leaves nothing
        directed_rows.push_back(row_known(12'd2048, 1'b1, 12'd0, 7'd0));
        directed_rows.push_back(row_item(12'd4095, 1'b0));
        directed_rows.push_back(row_item(12'd0, 1'b0));
        directed_rows.push_back(row_item(12'd4095, 1'b1));
        directed_rows.push_back(row_item(12'd0, 1'b1));
        directed_rows.push_back(row_write(mlm_pkg::REG_WEIGHT, 32'd65535));
        directed_rows.push_back(row_item(12'd4095, 1'b0));
        directed_rows.push_back(row_item(12'd0, 1'b1));
        directed_rows.push_back(row_write(mlm_pkg::REG_FULL, 32'd0));
        directed_rows.push_back(row_item(12'd3000, 1'b1));
        directed_rows.push_back(row_write(mlm_pkg::REG_FULL, 32'd1));
        directed_rows.push_back(row_item(12'd4095, 1'b1));
        directed_rows.push_back(row_write(mlm_pkg::REG_FULL, 32'd65535));
        directed_rows.push_back(row_item(12'd0, 1'b1));
        directed_rows.push_back(row_write(mlm_pkg::REG_DC_SHIFT, 32'd0));
        directed_rows.push_back(row_item(12'd4095, 1'b0));
        directed_rows.push_back(row_item(12'd0, 1'b1));
        directed_rows.push_back(row_write(mlm_pkg::REG_DC_SHIFT, 32'd15));
        // partial block stays open across the start-level write
        directed_rows.push_back(row_item(12'd4095, 1'b0));
        directed_rows.push_back(row_write(mlm_pkg::REG_DC_START, 32'd4095));
        directed_rows.push_back(row_write(mlm_pkg::REG_WEIGHT, 32'd0));
        // level was cleared and a zero weight keeps it there
        directed_rows.push_back(row_known(12'd0, 1'b1, 12'd0, 7'd0));
        directed_rows.push_back(row_write(mlm_pkg::REG_DC_START, 32'd0));
        directed_rows.push_back(row_write(mlm_pkg::REG_WEIGHT, 32'd32768));
        directed_rows.push_back(row_write(mlm_pkg::REG_FULL, 32'd4095));
        directed_rows.push_back(row_item(12'd4095, 1'b1));
        directed_rows.push_back(row_item(12'd4095, 1'b1));
        directed_rows.push_back(row_item(12'd2048, 1'b1));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            if (row.is_write) begin
                drain_results();
                reg_write(row.reg_idx, row.wdata);
            end else begin
                kres.level = row.level;
                kres.pct = row.pct;
                send_sample(row.sample, row.last, row.known, kres);
            end
        end

        for (p = 0; p < 8; p++) begin
            random_settings();
            random_phase(206);
        end

        drain_results();
        if (fails == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

endmodule
